### src/lj_pkg.sv
// Shared types and constants for the Lennard-Jones pair kernel.
`default_nettype none
package lj_pkg;

  localparam int COORD_W  = 24;
  localparam int BOX_W    = 23;
  localparam int CUT_W    = 32;
  localparam int SHIFT_W  = 32;
  localparam int OUT_W    = 48;
  localparam int Q_W      = 64;
  localparam int WRAP_W   = 25;
  localparam int SQ_W     = 49;
  localparam int R2_W     = 51;
  localparam int ACC_W    = 70;
  localparam int DIV_STAGES = 64;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam logic [BOX_W-1:0]          BOX_RST    = 23'd655360;
  localparam logic [CUT_W-1:0]          CUTOFF_RST = 32'd589824;
  localparam logic signed [SHIFT_W-1:0] SHIFT_RST  = 32'sd359;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 48'sh8000_0000_0000;
  localparam logic [Q_W-1:0] E_LIM = 64'h0400_0000_0000_0000;
  localparam logic [Q_W-1:0] F_LIM = 64'h0200_0000_0000_0000;

  typedef enum logic [2:0] {
    REG_BOX_X,
    REG_BOX_Y,
    REG_BOX_Z,
    REG_CUTOFF_SQ,
    REG_ENERGY_SHIFT
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
    logic signed [COORD_W-1:0] dz;
  } pair_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] energy;
    logic signed [OUT_W-1:0] force_factor;
    logic                    within_cutoff;
    logic                    saturated;
  } result_t;

  typedef struct packed {
    logic [Q_W-1:0] v;
    logic           big;
  } qval_t;

  typedef struct packed {
    logic [BOX_W-1:0]          box_x;
    logic [BOX_W-1:0]          box_y;
    logic [BOX_W-1:0]          box_z;
    logic [CUT_W-1:0]          cutoff_sq;
    logic signed [SHIFT_W-1:0] energy_shift;
  } cfg_t;

  typedef struct packed {
    qval_t i3;
    qval_t i4;
    qval_t i6;
    qval_t i7;
    logic  in_cut;
  } pows_t;

endpackage
`default_nettype wire

### src/lj_pre.sv
// Minimum-image wrap, squaring, cutoff compare and scaling of r2.
`default_nettype none
module lj_pre #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          in_valid,
  input  wire lj_pkg::pair_t pair,
  input  wire lj_pkg::cfg_t  cfg,
  output logic               out_valid,
  output lj_pkg::qval_t      w,
  output logic               in_cut
);

  localparam int SQ_FRAC = 2 * COORD_FRAC_BITS;
  localparam int CUT_SH  = SQ_FRAC - 16;
  localparam int RSH     = (SQ_FRAC >= 32) ? SQ_FRAC - 32 : 0;
  localparam int LSH     = (SQ_FRAC >= 32) ? 0 : 32 - SQ_FRAC;

  function automatic logic signed [lj_pkg::WRAP_W-1:0] wrap(
    input logic signed [lj_pkg::COORD_W-1:0] d,
    input logic [lj_pkg::BOX_W-1:0] len
  );
    logic signed [lj_pkg::WRAP_W:0]   d2;
    logic signed [lj_pkg::WRAP_W:0]   l2;
    logic signed [lj_pkg::WRAP_W-1:0] de;
    logic signed [lj_pkg::WRAP_W-1:0] le;
    d2 = {d[lj_pkg::COORD_W-1], d, 1'b0};
    l2 = $signed({3'b000, len});
    de = lj_pkg::WRAP_W'(d);
    le = $signed({2'b00, len});
    if (d2 > l2) begin
      wrap = de - le;
    end else if (d2 < -l2) begin
      wrap = de + le;
    end else begin
      wrap = de;
    end
  endfunction

  logic                             v1, v2, v3;
  logic signed [lj_pkg::WRAP_W-1:0] wx, wy, wz;
  logic [lj_pkg::SQ_W-1:0]          sx, sy, sz;
  logic signed [2*lj_pkg::WRAP_W-1:0] px, py, pz;
  logic [lj_pkg::R2_W-1:0]          r2;
  logic [lj_pkg::Q_W-1:0]           r2_64;
  logic [lj_pkg::Q_W-1:0]           w_c;
  logic                             within_c;

  assign px = wx * wx;
  assign py = wy * wy;
  assign pz = wz * wz;

  assign r2       = lj_pkg::R2_W'(sx) + lj_pkg::R2_W'(sy) + lj_pkg::R2_W'(sz);
  assign r2_64    = lj_pkg::Q_W'(r2);
  assign within_c = r2_64 <= (lj_pkg::Q_W'(cfg.cutoff_sq) << CUT_SH);
  assign w_c      = (r2_64 >> RSH) << LSH;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wx     <= wrap(pair.dx, cfg.box_x);
      wy     <= wrap(pair.dy, cfg.box_y);
      wz     <= wrap(pair.dz, cfg.box_z);
      sx     <= px[lj_pkg::SQ_W-1:0];
      sy     <= py[lj_pkg::SQ_W-1:0];
      sz     <= pz[lj_pkg::SQ_W-1:0];
      w.v    <= w_c;
      w.big  <= w_c < 64'd2;
      in_cut <= within_c;
    end
  end

  assign out_valid = v3;

endmodule
`default_nettype wire

### src/lj_recip.sv
// Pipelined restoring divider forming floor(2^64 / W), one quotient bit per stage.
`default_nettype none
module lj_recip (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          in_valid,
  input  wire lj_pkg::qval_t den,
  input  wire logic          within_in,
  output logic               out_valid,
  output lj_pkg::qval_t      recip,
  output logic               within_out
);

  localparam int N = lj_pkg::DIV_STAGES;

  logic [lj_pkg::Q_W-1:0] rem   [0:N-1];
  logic [lj_pkg::Q_W-1:0] quo   [0:N-1];
  lj_pkg::qval_t          dn    [0:N-1];
  logic                   vld   [0:N-1];
  logic                   wc    [0:N-1];

  logic [lj_pkg::Q_W-1:0] p_rem [0:N-1];
  logic [lj_pkg::Q_W-1:0] p_quo [0:N-1];
  lj_pkg::qval_t          p_dn  [0:N-1];
  logic                   p_vld [0:N-1];
  logic                   p_wc  [0:N-1];
  logic [lj_pkg::Q_W:0]   t     [0:N-1];
  logic [lj_pkg::Q_W:0]   diff  [0:N-1];
  logic                   ge    [0:N-1];

  for (genvar k = 0; k < N; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign p_rem[k] = lj_pkg::Q_W'(1);
      assign p_quo[k] = '0;
      assign p_dn[k]  = den;
      assign p_vld[k] = in_valid;
      assign p_wc[k]  = within_in;
    end else begin : g_next
      assign p_rem[k] = rem[k-1];
      assign p_quo[k] = quo[k-1];
      assign p_dn[k]  = dn[k-1];
      assign p_vld[k] = vld[k-1];
      assign p_wc[k]  = wc[k-1];
    end

    assign t[k]    = {p_rem[k], 1'b0};
    assign diff[k] = t[k] - {1'b0, p_dn[k].v};
    assign ge[k]   = t[k] >= {1'b0, p_dn[k].v};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= p_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k] <= ge[k] ? diff[k][lj_pkg::Q_W-1:0] : t[k][lj_pkg::Q_W-1:0];
        quo[k] <= {p_quo[k][lj_pkg::Q_W-2:0], ge[k]};
        dn[k]  <= p_dn[k];
        wc[k]  <= p_wc[k];
      end
    end
  end

  assign out_valid  = vld[N-1];
  assign recip.v    = quo[N-1];
  assign recip.big  = dn[N-1].big;
  assign within_out = wc[N-1];

endmodule
`default_nettype wire

### src/lj_mul.sv
// Two-stage Q32.32 product with overflow flag, built from 32x32 partial products.
`default_nettype none
module lj_mul (
  input  wire logic          clk,
  input  wire logic          adv,
  input  wire lj_pkg::qval_t a,
  input  wire lj_pkg::qval_t b,
  output lj_pkg::qval_t      p
);

  logic [63:0] hh_c, hl_c, lh_c, ll_c;
  logic [63:0] hh, hl, lh, ll;
  logic        big0;
  logic [95:0] sum;

  assign hh_c = a.v[63:32] * b.v[63:32];
  assign hl_c = a.v[63:32] * b.v[31:0];
  assign lh_c = a.v[31:0] * b.v[63:32];
  assign ll_c = a.v[31:0] * b.v[31:0];

  assign sum = {hh, 32'd0} + {32'd0, hl} + {32'd0, lh} + {64'd0, ll[63:32]};

  always_ff @(posedge clk) begin
    if (adv) begin
      hh    <= hh_c;
      hl    <= hl_c;
      lh    <= lh_c;
      ll    <= ll_c;
      big0  <= a.big | b.big;
      p.v   <= sum[63:0];
      p.big <= big0 | (|sum[95:63]);
    end
  end

endmodule
`default_nettype wire

### src/lj_pow.sv
// Reciprocal power chain: 1/r^6, 1/r^8, 1/r^12 and 1/r^14 over four multiply levels.
`default_nettype none
module lj_pow (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          in_valid,
  input  wire lj_pkg::qval_t recip,
  input  wire logic          within_in,
  output logic               out_valid,
  output lj_pkg::pows_t      pows
);

  lj_pkg::qval_t i2, i3, i4, i6, i7;
  lj_pkg::qval_t rd  [0:5];
  lj_pkg::qval_t i3d [0:3];
  lj_pkg::qval_t i4d [0:3];
  lj_pkg::qval_t i6d [0:1];
  logic          vd  [0:7];
  logic          wd  [0:7];

  lj_mul u_m2 (.clk(clk), .adv(adv), .a(recip), .b(recip), .p(i2));
  lj_mul u_m3 (.clk(clk), .adv(adv), .a(i2),    .b(rd[1]), .p(i3));
  lj_mul u_m4 (.clk(clk), .adv(adv), .a(i2),    .b(i2),    .p(i4));
  lj_mul u_m6 (.clk(clk), .adv(adv), .a(i3),    .b(i3),    .p(i6));
  lj_mul u_m7 (.clk(clk), .adv(adv), .a(i6),    .b(rd[5]), .p(i7));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 8; k++) begin
        vd[k] <= 1'b0;
      end
    end else if (adv) begin
      vd[0] <= in_valid;
      for (int k = 1; k < 8; k++) begin
        vd[k] <= vd[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd[0]  <= recip;
      wd[0]  <= within_in;
      i3d[0] <= i3;
      i4d[0] <= i4;
      i6d[0] <= i6;
      i6d[1] <= i6d[0];
      for (int k = 1; k < 6; k++) begin
        rd[k] <= rd[k-1];
      end
      for (int k = 1; k < 8; k++) begin
        wd[k] <= wd[k-1];
      end
      for (int k = 1; k < 4; k++) begin
        i3d[k] <= i3d[k-1];
        i4d[k] <= i4d[k-1];
      end
    end
  end

  assign out_valid   = vd[7];
  assign pows.i3     = i3d[3];
  assign pows.i4     = i4d[3];
  assign pows.i6     = i6d[1];
  assign pows.i7     = i7;
  assign pows.in_cut = wd[7];

endmodule
`default_nettype wire

### src/lennard_jones_pair_kernel_top.sv
// Top level of the Lennard-Jones pair kernel: registers, pipeline and output stage.
//
//   channel   direction  handshake                 payload
//   pair      in         pair_valid / pair_ready   lj_pkg::pair_t (dx, dy, dz)
//   result    out        result_valid/result_ready lj_pkg::result_t
//   apb       in         psel, penable, pready     paddr, pwdata, prdata
//
// One pair per cycle while no held result stalls the pipeline. Stages in order: wrap,
// square and cutoff; the bit-per-stage reciprocal divider; the four multiply levels; the output.
// Reset clears all valid bits and loads the register defaults.
// A held result stalls the whole pipeline together; nothing is dropped or repeated.
`default_nettype none
module lennard_jones_pair_kernel_top #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        pair_valid,
  output logic                             pair_ready,
  input  wire lj_pkg::pair_t               pair,
  output logic                             result_valid,
  input  wire logic                        result_ready,
  output lj_pkg::result_t                  result,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lj_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [lj_pkg::DATA_W-1:0]   pwdata,
  output logic [lj_pkg::DATA_W-1:0]        prdata,
  output logic                             pready
);

  lj_pkg::cfg_t     cfg;
  lj_pkg::reg_idx_t idx;
  logic             adv;
  logic             pre_valid, div_valid, pow_valid;
  lj_pkg::qval_t    w, recip;
  logic             pre_within, div_within;
  lj_pkg::pows_t    pows;
  lj_pkg::result_t  result_next;

  logic signed [lj_pkg::ACC_W-1:0] acc_e, acc_f, e_sh, f_sh, i4s, i7s;
  logic                            ebig, fbig;

  assign pready     = 1'b1;
  assign idx        = lj_pkg::reg_idx_t'(paddr[4:2]);
  assign adv        = !result_valid || result_ready;
  assign pair_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_x        <= lj_pkg::BOX_RST;
      cfg.box_y        <= lj_pkg::BOX_RST;
      cfg.box_z        <= lj_pkg::BOX_RST;
      cfg.cutoff_sq    <= lj_pkg::CUTOFF_RST;
      cfg.energy_shift <= lj_pkg::SHIFT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        lj_pkg::REG_BOX_X:        cfg.box_x        <= pwdata[lj_pkg::BOX_W-1:0];
        lj_pkg::REG_BOX_Y:        cfg.box_y        <= pwdata[lj_pkg::BOX_W-1:0];
        lj_pkg::REG_BOX_Z:        cfg.box_z        <= pwdata[lj_pkg::BOX_W-1:0];
        lj_pkg::REG_CUTOFF_SQ:    cfg.cutoff_sq    <= pwdata;
        lj_pkg::REG_ENERGY_SHIFT: cfg.energy_shift <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lj_pkg::REG_BOX_X:        prdata = lj_pkg::DATA_W'(cfg.box_x);
      lj_pkg::REG_BOX_Y:        prdata = lj_pkg::DATA_W'(cfg.box_y);
      lj_pkg::REG_BOX_Z:        prdata = lj_pkg::DATA_W'(cfg.box_z);
      lj_pkg::REG_CUTOFF_SQ:    prdata = cfg.cutoff_sq;
      lj_pkg::REG_ENERGY_SHIFT: prdata = cfg.energy_shift;
      default:                  prdata = '0;
    endcase
  end

  lj_pre #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_pre (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(pair_valid), .pair(pair), .cfg(cfg),
    .out_valid(pre_valid), .w(w), .in_cut(pre_within)
  );

  lj_recip u_recip (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(pre_valid), .den(w), .within_in(pre_within),
    .out_valid(div_valid), .recip(recip), .within_out(div_within)
  );

  lj_pow u_pow (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(div_valid), .recip(recip), .within_in(div_within),
    .out_valid(pow_valid), .pows(pows)
  );

  assign ebig = pows.i6.big || (pows.i6.v > lj_pkg::E_LIM);
  assign fbig = pows.i7.big || (pows.i7.v > lj_pkg::F_LIM) ||
                pows.i4.big || (pows.i4.v > lj_pkg::F_LIM);

  assign i4s   = $signed({6'd0, pows.i4.v});
  assign i7s   = $signed({6'd0, pows.i7.v});
  assign acc_e = (($signed({6'd0, pows.i6.v}) - $signed({6'd0, pows.i3.v})) <<< 2) +
                 (lj_pkg::ACC_W'(cfg.energy_shift) <<< 16);
  assign acc_f = (i4s <<< 4) + (i4s <<< 3) - (i7s <<< 5) - (i7s <<< 4);
  assign e_sh  = acc_e >>> 8;
  assign f_sh  = acc_f >>> 8;

  always_comb begin
    result_next.energy        = '0;
    result_next.force_factor  = '0;
    result_next.within_cutoff = pows.in_cut;
    result_next.saturated     = 1'b0;
    if (pows.in_cut) begin
      if (ebig) begin
        result_next.energy    = lj_pkg::OUT_MAX;
        result_next.saturated = 1'b1;
      end else if (e_sh > lj_pkg::ACC_W'(lj_pkg::OUT_MAX)) begin
        result_next.energy    = lj_pkg::OUT_MAX;
        result_next.saturated = 1'b1;
      end else if (e_sh < lj_pkg::ACC_W'(lj_pkg::OUT_MIN)) begin
        result_next.energy    = lj_pkg::OUT_MIN;
        result_next.saturated = 1'b1;
      end else begin
        result_next.energy    = e_sh[lj_pkg::OUT_W-1:0];
      end
      if (fbig) begin
        result_next.force_factor = lj_pkg::OUT_MIN;
        result_next.saturated    = 1'b1;
      end else if (f_sh > lj_pkg::ACC_W'(lj_pkg::OUT_MAX)) begin
        result_next.force_factor = lj_pkg::OUT_MAX;
        result_next.saturated    = 1'b1;
      end else if (f_sh < lj_pkg::ACC_W'(lj_pkg::OUT_MIN)) begin
        result_next.force_factor = lj_pkg::OUT_MIN;
        result_next.saturated    = 1'b1;
      end else begin
        result_next.force_factor = f_sh[lj_pkg::OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= pow_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire
